@@ sv/dc_tracking_voice_activity_detector_assert.svh @@
// assertion macros for the dc tracking voice activity detector
// used by the top level only; expects clk and rst_n in the including scope
`ifndef DC_TRACKING_VOICE_ACTIVITY_DETECTOR_ASSERT_SVH
`define DC_TRACKING_VOICE_ACTIVITY_DETECTOR_ASSERT_SVH

// same-cycle implication
`define DCTVAD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCTVAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dctvad_pkg.sv @@
// shared constants and types for the dc tracking voice activity detector
// no dependencies; used by every module and the top level
package dctvad_pkg;

    localparam int FRAME_LEN_DEFAULT = 160;

    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 20;
    localparam int DC_W        = 20;
    localparam int DC_FRAC_W   = 8;
    localparam int QUOT_W      = 20;
    localparam int NUM_W       = SUM_W + DC_FRAC_W;
    localparam int LEN_W       = 8;
    localparam int RECIP_W     = 28;
    localparam int PROD_W      = 48;
    localparam int X_W         = 24;
    localparam int OUT_W       = 16;
    localparam int MAG_W       = OUT_W + 1;
    localparam int MAG_THR_W   = 16;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DC_W-1:0]      DC_RESET       = DC_W'(1891 << DC_FRAC_W);
    localparam logic [MAG_THR_W-1:0] MAG_THR_RESET  = 16'd2000;
    localparam logic [CNT_W-1:0]     LOUD_THR_RESET = 8'd30;

    localparam logic [3:0] GAIN       = 4'd14;
    localparam logic [3:0] OLD_WEIGHT = 4'd9;

    // x / 10 == (x * ceil(2^27 / 10)) >> 27, exact for x below 2^26
    localparam logic [X_W-1:0] DIV10_MUL   = 24'd13421773;
    localparam int             DIV10_SHIFT = 27;

    localparam logic [CFG_IDX_W-1:0] REG_MAG_THRESHOLD  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_THRESHOLD = 8'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                clear_active;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] centered_sample;
        logic                    frame_end;
        logic                    frame_voiced;
        logic                    voice_active;
        logic                    voice_onset;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_req_t;

    // input stage to dc pipeline
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
        logic                clr;
        logic                fend;
        logic [SUM_W-1:0]    sum;
    } acc_item_t;

    // dc pipeline to detection stage
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
        logic                clr;
        logic                fend;
    } det_item_t;

    typedef struct packed {
        logic [MAG_THR_W-1:0] mag_thr;
        logic [CNT_W-1:0]     loud_thr;
    } thr_t;

endpackage

@@ sv/dctvad_stream_if.sv @@
// valid/ready channel carrying one payload per request
// no dependencies; the payload type is set where the channel is declared
interface dctvad_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

@@ sv/dc_tracking_voice_activity_detector.sv @@
// each request passes the input register, the three dc stages and the result register
// throughput: one sample per cycle; the whole pipeline holds while a result waits
// the dc update runs in three registered stages (reciprocal multiply, correction,
// divide-by-ten multiply) and commits as the frame-end sample reaches the result register
// reset: thresholds 2000 and 30, dc level 1891.0, frame counters and activity clear
// depends on dctvad_pkg, dctvad_stream_if and the three pipeline modules
`include "dc_tracking_voice_activity_detector_assert.svh"

module dc_tracking_voice_activity_detector
    import dctvad_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    dctvad_stream_if.sink   item,
    dctvad_stream_if.source result,
    dctvad_stream_if.sink   cfg
);

    logic [MAG_THR_W-1:0] mag_thr_reg;
    logic [CNT_W-1:0]     loud_thr_reg;
    logic                 advance;
    acc_item_t            acc;
    det_item_t            det;
    logic [SAMPLE_W-1:0]  dc_int;
    thr_t                 thr;

    assign advance  = !result.valid || result.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_thr_reg  <= MAG_THR_RESET;
            loud_thr_reg <= LOUD_THR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_MAG_THRESHOLD:  mag_thr_reg  <= cfg.payload.data[MAG_THR_W-1:0];
                REG_LOUD_THRESHOLD: loud_thr_reg <= cfg.payload.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign thr.mag_thr  = mag_thr_reg;
    assign thr.loud_thr = loud_thr_reg;

    dctvad_frame_acc #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .acc     (acc)
    );

    dctvad_dc_track #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dc_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .acc     (acc),
        .det     (det),
        .dc_int  (dc_int)
    );

    dctvad_detect u_detect (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .det     (det),
        .dc_int  (dc_int),
        .thr     (thr),
        .result  (result)
    );

    `DCTVAD_ASSERT_IMPL(a_onset_needs_voiced_end, result.valid && result.payload.voice_onset, result.payload.frame_voiced && result.payload.frame_end, "voice onset outside a voiced frame end")
    `DCTVAD_ASSERT_IMPL(a_voiced_sets_active, result.valid && result.payload.frame_voiced, result.payload.voice_active, "voiced frame left activity clear")
    `DCTVAD_ASSERT_IMPL(a_no_accept_on_stall, item.valid && item.ready, !result.valid || result.ready, "request accepted while the pipeline is held")
    `DCTVAD_ASSERT_NEXT(a_accept_fills_stage, item.valid && item.ready, acc.valid, "accepted request missing from the input stage")

endmodule

@@ sv/dctvad_frame_acc.sv @@
// input register with frame position and raw sample sum
// depends on dctvad_pkg and dctvad_stream_if
module dctvad_frame_acc
    import dctvad_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    dctvad_stream_if.sink   item,
    output acc_item_t       acc
);

    localparam int               IDX_W    = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                clr_reg;
    logic                fend_reg;
    logic [SUM_W-1:0]    total_reg;

    logic                accept;
    logic                is_last;
    logic [SUM_W-1:0]    sum_total;

    assign item.ready = advance;
    assign accept     = item.valid && advance;
    assign is_last    = idx_reg >= LAST_IDX;
    assign sum_total  = sum_reg + SUM_W'(item.payload.adc_sample);

    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (is_last)
            begin
                idx_next = '0;
                sum_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                sum_next = sum_total;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            if (advance)
            begin
                valid_reg <= item.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= item.payload.adc_sample;
            clr_reg    <= item.payload.clear_active;
            fend_reg   <= is_last;
            total_reg  <= sum_total;
        end
    end

    assign acc.valid  = valid_reg;
    assign acc.sample = sample_reg;
    assign acc.clr    = clr_reg;
    assign acc.fend   = fend_reg;
    assign acc.sum    = total_reg;

endmodule

@@ sv/dctvad_dc_track.sv @@
// three-stage pipeline computing the next dc level at frame end
// depends on dctvad_pkg; feeds dctvad_detect
module dctvad_dc_track
    import dctvad_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  acc_item_t           acc,
    output det_item_t           det,
    output logic [SAMPLE_W-1:0] dc_int
);

    // reciprocal of the frame length, leaves the quotient at most one short
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / FRAME_LEN);
    localparam logic [LEN_W-1:0]   LEN   = LEN_W'(FRAME_LEN);
    localparam int                 QSHIFT = RECIP_W - DC_FRAC_W;

    logic [DC_W-1:0]     dc_reg;

    logic                v1_reg, v2_reg, v3_reg;
    logic [SAMPLE_W-1:0] s1_reg, s2_reg, s3_reg;
    logic                c1_reg, c2_reg, c3_reg;
    logic                f1_reg, f2_reg, f3_reg;
    logic [SUM_W-1:0]    sum1_reg, sum2_reg;
    logic [PROD_W-1:0]   prod1_reg, prod3_reg;
    logic [QUOT_W-1:0]   q0_reg;
    logic [NUM_W-1:0]    p2_reg;

    logic [PROD_W-1:0]   prod1_next;
    logic [QUOT_W-1:0]   q0_next;
    logic [NUM_W-1:0]    p2_next;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    rem;
    logic [QUOT_W-1:0]   mean;
    logic [X_W-1:0]      x;
    logic [PROD_W-1:0]   prod3_next;

    // mean_q8 = floor(sum * 256 / FRAME_LEN)
    assign prod1_next = PROD_W'(acc.sum) * PROD_W'(RECIP);
    assign q0_next    = prod1_reg[QSHIFT +: QUOT_W];
    assign p2_next    = NUM_W'(q0_next) * NUM_W'(LEN);
    assign num        = {sum2_reg, {DC_FRAC_W{1'b0}}};
    assign rem        = num - p2_reg;
    assign mean       = q0_reg + QUOT_W'(rem >= NUM_W'(LEN));

    // 9 * dc + mean, then divide by ten
    assign x          = X_W'(dc_reg) * X_W'(OLD_WEIGHT) + X_W'(mean);
    assign prod3_next = PROD_W'(x) * PROD_W'(DIV10_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            dc_reg <= DC_RESET;
        end
        else if (advance)
        begin
            v1_reg <= acc.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            // commits as the frame-end sample leaves, so it still sees the old level
            if (v3_reg && f3_reg)
            begin
                dc_reg <= prod3_reg[DIV10_SHIFT +: DC_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg    <= acc.sample;
            c1_reg    <= acc.clr;
            f1_reg    <= acc.fend;
            sum1_reg  <= acc.sum;
            prod1_reg <= prod1_next;

            s2_reg    <= s1_reg;
            c2_reg    <= c1_reg;
            f2_reg    <= f1_reg;
            sum2_reg  <= sum1_reg;
            q0_reg    <= q0_next;
            p2_reg    <= p2_next;

            s3_reg    <= s2_reg;
            c3_reg    <= c2_reg;
            f3_reg    <= f2_reg;
            prod3_reg <= prod3_next;
        end
    end

    assign det.valid  = v3_reg;
    assign det.sample = s3_reg;
    assign det.clr    = c3_reg;
    assign det.fend   = f3_reg;
    assign dc_int     = dc_reg[DC_W-1:DC_FRAC_W];

endmodule

@@ sv/dctvad_detect.sv @@
// centering, loud sample count, voicing flags and the result register
// depends on dctvad_pkg and dctvad_stream_if
module dctvad_detect
    import dctvad_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  det_item_t           det,
    input  logic [SAMPLE_W-1:0] dc_int,
    input  thr_t                thr,
    dctvad_stream_if.source     result
);

    logic             active_reg, active_next;
    logic [CNT_W-1:0] loud_reg, loud_next;
    logic             valid_reg;
    out_item_t        out_reg;

    logic [OUT_W-1:0] diff;
    logic [OUT_W-1:0] scaled;
    logic [MAG_W-1:0] mag;
    logic             loud;
    logic             active_clr;
    logic [CNT_W-1:0] loud_inc;
    logic             voiced;
    logic             onset;
    logic             take;

    assign diff       = OUT_W'(det.sample) - OUT_W'(dc_int);
    assign scaled     = OUT_W'(diff * OUT_W'(GAIN));
    // most negative value counts as magnitude 32768
    assign mag        = scaled[OUT_W-1] ? (MAG_W'(1 << OUT_W) - MAG_W'(scaled))
                                        : MAG_W'(scaled);
    assign loud       = mag > MAG_W'(thr.mag_thr);
    assign active_clr = det.clr ? 1'b0 : active_reg;
    assign loud_inc   = loud_reg + CNT_W'(loud);
    assign voiced     = det.fend && (loud_inc > thr.loud_thr);
    assign onset      = voiced && !active_clr;
    assign take       = advance && det.valid;

    always_comb
    begin
        active_next = active_reg;
        loud_next   = loud_reg;
        if (take)
        begin
            active_next = active_clr || voiced;
            loud_next   = det.fend ? '0 : loud_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            loud_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            loud_reg   <= loud_next;
            if (advance)
            begin
                valid_reg <= det.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.centered_sample <= scaled;
            out_reg.frame_end       <= det.fend;
            out_reg.frame_voiced    <= voiced;
            out_reg.voice_active    <= active_next;
            out_reg.voice_onset     <= onset;
        end
    end

    assign result.valid   = valid_reg;
    assign result.payload = out_reg;

endmodule

@@ sim/testbench.sv @@
// self-checking bench for the dc tracking voice activity detector: directed corners,
// then random frames over several threshold settings, checked against a local predictor
// depends on dctvad_pkg, dctvad_stream_if and the detector top level
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dctvad_pkg::*;

    localparam int FRAME_LEN = FRAME_LEN_DEFAULT;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 149;
    localparam int MAX_REPORTS = 50;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [3:0] WEIGHT_SUM = 4'd10;

    class vad_scoreboard;
        logic [MAG_THR_W-1:0] mag_thr;
        logic [CNT_W-1:0]     loud_thr;
        logic [DC_W-1:0]      dc_level;
        logic [LEN_W-1:0]     pos;
        logic [SUM_W-1:0]     frame_sum;
        logic [CNT_W-1:0]     loud_n;
        logic                 active;
        out_item_t            expected_q[$];
        int                   errors;

        function new();
            mag_thr = MAG_THR_RESET;
            loud_thr = LOUD_THR_RESET;
            dc_level = DC_RESET;
            pos = '0;
            frame_sum = '0;
            loud_n = '0;
            active = 1'b0;
            errors = 0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MAG_THRESHOLD)
                mag_thr = data;
            else if (idx == REG_LOUD_THRESHOLD)
                loud_thr = data[CNT_W-1:0];
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction

        function void note_sample(in_item_t it);
            logic [SAMPLE_W-1:0] dc_int;
            logic [OUT_W-1:0]    scaled;
            logic [MAG_W-1:0]    mag;
            logic [63:0]         mean_q8;
            logic [63:0]         next_dc;
            out_item_t           res;
            dc_int = dc_level[DC_W-1:DC_FRAC_W];
            scaled = ({4'b0000, it.adc_sample} - {4'b0000, dc_int}) * GAIN;
            if (it.clear_active)
                active = 1'b0;
            // most negative value counts as magnitude 32768
            mag = scaled[OUT_W-1] ? 17'h10000 - {1'b0, scaled} : {1'b0, scaled};
            if (mag > {1'b0, mag_thr})
                loud_n = loud_n + 1'b1;
            frame_sum = frame_sum + SUM_W'(it.adc_sample);
            res = '0;
            res.centered_sample = scaled;
            if (int'(pos) >= FRAME_LEN - 1)
            begin
                // whole frame, last sample included, used the old dc level
                mean_q8 = (64'(frame_sum) << DC_FRAC_W) / 64'(FRAME_LEN);
                next_dc = (64'(OLD_WEIGHT) * 64'(dc_level) + mean_q8) / 64'(WEIGHT_SUM);
                dc_level = next_dc[DC_W-1:0];
                res.frame_end = 1'b1;
                if (loud_n > loud_thr)
                begin
                    res.frame_voiced = 1'b1;
                    res.voice_onset = !active;
                    active = 1'b1;
                end
                pos = '0;
                frame_sum = '0;
                loud_n = '0;
            end
            else
            begin
                pos = pos + 1'b1;
            end
            res.voice_active = active;
            expected_q.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d with no request waiting", got.centered_sample));
                return;
            end
            want = expected_q.pop_front();
            if (got.centered_sample !== want.centered_sample)
                report($sformatf("centered_sample %0d, want %0d",
                                 got.centered_sample, want.centered_sample));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
            if (got.frame_voiced !== want.frame_voiced)
                report($sformatf("frame_voiced %b, want %b",
                                 got.frame_voiced, want.frame_voiced));
            if (got.voice_active !== want.voice_active)
                report($sformatf("voice_active %b, want %b",
                                 got.voice_active, want.voice_active));
            if (got.voice_onset !== want.voice_onset)
                report($sformatf("voice_onset %b, want %b",
                                 got.voice_onset, want.voice_onset));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   idle_on = 1'b1;
    int   quiet_cycles = 0;

    vad_scoreboard sb = new();

    dctvad_stream_if #(.payload_t(in_item_t))  sample_bus ();
    dctvad_stream_if #(.payload_t(out_item_t)) result_bus ();
    dctvad_stream_if #(.payload_t(cfg_req_t))  cfg_bus ();

    dc_tracking_voice_activity_detector #(
        .FRAME_LEN(FRAME_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(sample_bus),
        .result(result_bus),
        .cfg(cfg_bus)
    );

    always #5ns clk = ~clk;

    // result side back-pressure in bursts
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_bus.ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
            begin
                result_bus.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.payload);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(input in_item_t it);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            sample_bus.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        sample_bus.payload = it;
        sample_bus.valid = 1'b1;
        do @(posedge clk); while (!sample_bus.ready);
        sb.note_sample(it);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_bus.payload.index = idx;
        cfg_bus.payload.data = data;
        cfg_bus.valid = 1'b1;
        do @(posedge clk); while (!cfg_bus.ready);
        sb.apply_register(idx, data);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // stop sending, let every result drain and the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        sample_bus.valid = 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int loud_pct, input bit extremes);
        int centre;
        int span;
        int s;
        centre = int'(sb.dc_level[DC_W-1:DC_FRAC_W]);
        if (extremes)
            return ($urandom_range(0, 1) != 0) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
        if (int'($urandom_range(0, 99)) < loud_pct)
            return SAMPLE_W'($urandom_range(0, 4095));
        // quiet samples sit near the dc level, some right at the loudness edge
        span = ($urandom_range(0, 1) != 0) ? 3 : int'(sb.mag_thr) / int'(GAIN) + 2;
        s = centre + int'($urandom_range(0, 2 * span)) - span;
        if (s < 0)
            s = 0;
        else if (s > 4095)
            s = 4095;
        return SAMPLE_W'(s);
    endfunction

    initial
    begin
        in_item_t             corner_items[12];
        in_item_t             it;
        int                   loud_pct;
        bit                   extremes;
        logic [MAG_THR_W-1:0] mag_set;
        logic [CNT_W-1:0]     loud_set;

        corner_items = '{
            '{12'd0, 1'b0}, '{12'd4095, 1'b0}, '{12'd1891, 1'b0}, '{12'd1892, 1'b0},
            '{12'd1890, 1'b1}, '{12'd2034, 1'b0}, '{12'd2033, 1'b0}, '{12'd1748, 1'b0},
            '{12'd1749, 1'b1}, '{12'd4095, 1'b1}, '{12'd0, 1'b1}, '{12'd2048, 1'b0}
        };
        sample_bus.valid = 1'b0;
        sample_bus.payload = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.payload = '0;
        loud_pct = 50;
        extremes = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset thresholds, samples around the initial dc level and the loudness edge
        foreach (corner_items[i])
            send_item(corner_items[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            case (p % 6)
                0: mag_set = '0;
                1: mag_set = '1;
                2: mag_set = 16'd32768;
                3: mag_set = 16'd2000;
                4: mag_set = 16'd32767;
                default: mag_set = MAG_THR_W'($urandom);
            endcase
            case ((p + 2) % 6)
                0: loud_set = '0;
                1: loud_set = '1;
                2: loud_set = 8'd160;
                3: loud_set = 8'd159;
                4: loud_set = 8'd30;
                default: loud_set = CNT_W'($urandom);
            endcase
            set_register(REG_MAG_THRESHOLD, mag_set);
            // upper data bits must be dropped by the count register
            set_register(REG_LOUD_THRESHOLD, {8'($urandom), loud_set});
            set_register(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (sb.pos == '0)
                begin
                    extremes = 1'b0;
                    case ($urandom_range(0, 4))
                        0: loud_pct = 0;
                        1: loud_pct = 100;
                        2: loud_pct = int'($urandom_range(0, 100));
                        3: extremes = 1'b1;
                        // aim the loud count at the voicing threshold
                        default: loud_pct = int'(sb.loud_thr) * 100 / FRAME_LEN
                                            + int'($urandom_range(0, 10)) - 5;
                    endcase
                end
                it.adc_sample = pick_sample(loud_pct, extremes);
                it.clear_active = ($urandom_range(0, 31) == 0);
                send_item(it);
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ dc_tracking_voice_activity_detector.f @@
+incdir+sv
sv/dctvad_pkg.sv
sv/dctvad_stream_if.sv
sv/dctvad_frame_acc.sv
sv/dctvad_dc_track.sv
sv/dctvad_detect.sv
sv/dc_tracking_voice_activity_detector.sv
sim/testbench.sv
